@@ rtl/ppp_pkg.sv @@
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants for the pinhole point projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FOCAL  = 3'd0;
  localparam logic [2:0] REG_CENTER = 3'd1;
  localparam logic [2:0] REG_IMAGE  = 3'd2;
  localparam logic [2:0] REG_ROW0   = 3'd3;
  localparam logic [2:0] REG_ROW1   = 3'd4;
  localparam logic [2:0] REG_ROW2   = 3'd5;

  // 0.05 m in Q16.16
  localparam logic signed [35:0] DEPTH_MIN = 36'sd3277;

  // quotient bits kept by each divider lane
  localparam int QW = 26;

  typedef struct packed {
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] rel_z;
    logic [23:0]        object_size;
  } in_t;

  typedef struct packed {
    logic signed [23:0] pixel_u;
    logic signed [23:0] pixel_v;
    logic [23:0]        size_pixels;
    logic               visible;
  } out_t;

  typedef struct packed {
    logic [23:0]       fx;
    logic [23:0]       fy;
    logic [23:0]       cx;
    logic [23:0]       cy;
    logic [15:0]       width;
    logic [15:0]       height;
    logic [8:0][15:0]  mount;
  } cfg_t;

  // camera-frame point, Q16.16
  typedef struct packed {
    logic signed [35:0] px;
    logic signed [35:0] py;
    logic signed [35:0] pz;
    logic [23:0]        size;
  } cam_t;

endpackage

`default_nettype wire

@@ rtl/ppp_front.sv @@
// ----------------------------------------------------------------------------
// ppp_front
// Accepts points and rotates them into the camera frame (two stages).
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_front (
  input  wire               clk,
  input  wire               rst,
  input  ppp_pkg::cfg_t     cfg,
  input  wire               in_valid,
  output logic              in_ready,
  input  ppp_pkg::in_t      in_data,
  output logic              cam_valid,
  input  wire               cam_ready,
  output ppp_pkg::cam_t     cam_data
);
  import ppp_pkg::*;

  logic               v1;
  logic signed [47:0] prod [9];
  logic signed [47:0] prod_next [9];
  logic [23:0]        size1;
  logic               v2;
  cam_t               cam;
  cam_t               cam_next;
  logic               en;
  logic signed [31:0] rel [3];
  logic signed [49:0] acc [3];

  // whole front advances when its last stage is empty or drains
  assign en       = !v2 || cam_ready;
  assign in_ready = en;

  // nine mount products
  always_comb begin
    rel[0] = in_data.rel_x;
    rel[1] = in_data.rel_y;
    rel[2] = in_data.rel_z;
    for (int i = 0; i < 9; i++) begin
      prod_next[i] = $signed(cfg.mount[i]) * rel[i % 3];
    end
  end

  // row sums, floor shift by 14
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = {{2{prod[3*r][47]}}, prod[3*r]} + {{2{prod[3*r+1][47]}}, prod[3*r+1]}
             + {{2{prod[3*r+2][47]}}, prod[3*r+2]};
    end
    cam_next.px   = acc[0][49:14];
    cam_next.py   = acc[1][49:14];
    cam_next.pz   = acc[2][49:14];
    cam_next.size = size1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        prod[i] <= prod_next[i];
      end
      size1 <= in_data.object_size;
      cam   <= cam_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  assign cam_valid = v2;
  assign cam_data  = cam;

endmodule

`default_nettype wire

@@ rtl/ppp_fifo.sv @@
// ----------------------------------------------------------------------------
// ppp_fifo
// Short queue between the transform front and the projection back.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_fifo #(
  parameter int DEPTH = 4
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  ppp_pkg::cam_t  push_data,
  output logic           full,
  input  wire            pop,
  output logic           nonempty,
  output ppp_pkg::cam_t  pop_data
);
  import ppp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cam_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ppp_div.sv @@
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined unsigned restoring divider, one quotient bit per stage,
// quotient saturated to all ones when it does not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_div (
  input  wire                    clk,
  input  wire                    en,
  input  wire  [58:0]            num,
  input  wire  [34:0]            den,
  output logic [ppp_pkg::QW-1:0] quot
);
  import ppp_pkg::*;

  logic [34:0]   rem  [QW+1];
  logic [QW-1:0] bits [QW+1];
  logic [34:0]   dq   [QW+1];
  logic          ovf  [QW+1];

  // initial partial remainder and overflow check
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {2'b00, num[58:QW]};
      bits[0] <= num[QW-1:0];
      dq[0]   <= den;
      ovf[0]  <= ({2'b00, num[58:QW]} >= den);
    end
  end

  // one quotient bit per stage
  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [35:0] t;
    logic [35:0] diff;
    logic        ge;

    assign t    = {rem[i-1], bits[i-1][QW-1]};
    assign diff = t - {1'b0, dq[i-1]};
    assign ge   = (t >= {1'b0, dq[i-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? diff[34:0] : t[34:0];
        bits[i] <= {bits[i-1][QW-2:0], ge};
        dq[i]   <= dq[i-1];
        ovf[i]  <= ovf[i-1];
      end
    end
  end

  assign quot = ovf[QW] ? '1 : bits[QW];

endmodule

`default_nettype wire

@@ rtl/ppp_back.sv @@
// ----------------------------------------------------------------------------
// ppp_back
// Projects camera-frame points: three divider lanes, offset, clamp and
// image bounds test, with the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_back (
  input  wire               clk,
  input  wire               rst,
  input  ppp_pkg::cfg_t     cfg,
  input  wire               cam_valid,
  output logic              cam_pop,
  input  ppp_pkg::cam_t     cam_data,
  output logic              out_valid,
  input  wire               out_ready,
  output ppp_pkg::out_t     out_data
);
  import ppp_pkg::*;

  localparam int LAT = QW + 1;

  typedef struct packed {
    logic valid;
    logic neg_u;
    logic neg_v;
    logic near;
  } side_t;

  logic        en;
  logic [58:0] num_u, num_v, num_s;
  logic [34:0] den;
  side_t       side_p;
  side_t       side [LAT];
  logic [35:0] ax, ay;
  logic [QW-1:0] q_u, q_v, q_s;
  out_t        res, res_next;
  logic signed [QW:0]  qs_u, qs_v;
  logic signed [27:0]  u, v;
  logic [27:0] w_lim, h_lim;

  // whole back advances when the output register is free or taken
  assign en      = !out_valid || out_ready;
  assign cam_pop = en && cam_valid;

  // magnitudes and focal products
  assign ax = cam_data.px[35] ? 36'(-cam_data.px) : cam_data.px;
  assign ay = cam_data.py[35] ? 36'(-cam_data.py) : cam_data.py;

  always_ff @(posedge clk) begin
    if (en) begin
      num_u <= 59'({36'd0, cfg.fx} * {24'd0, ax});
      num_v <= 59'({36'd0, cfg.fy} * {24'd0, ay});
      num_s <= {11'd0, 48'({24'd0, cfg.fx} * {24'd0, cam_data.size})};
      den   <= cam_data.pz[34:0];
      side_p.neg_u <= cam_data.px[35];
      side_p.neg_v <= cam_data.py[35];
      side_p.near  <= (cam_data.pz <= DEPTH_MIN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_p.valid <= 1'b0;
    end else if (en) begin
      side_p.valid <= cam_valid;
    end
  end

  ppp_div u_div_u (.clk(clk), .en(en), .num(num_u), .den(den), .quot(q_u));
  ppp_div u_div_v (.clk(clk), .en(en), .num(num_v), .den(den), .quot(q_v));
  ppp_div u_div_s (.clk(clk), .en(en), .num(num_s), .den(den), .quot(q_s));

  // side information follows the divider lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        side[i] <= '0;
      end
    end else if (en) begin
      side[0] <= side_p;
      for (int i = 1; i < LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // offset, bounds test and clamp
  always_comb begin
    qs_u  = side[LAT-1].neg_u ? -$signed({1'b0, q_u}) : $signed({1'b0, q_u});
    qs_v  = side[LAT-1].neg_v ? -$signed({1'b0, q_v}) : $signed({1'b0, q_v});
    u     = $signed({4'd0, cfg.cx}) + 28'(qs_u);
    v     = $signed({4'd0, cfg.cy}) + 28'(qs_v);
    w_lim = {4'd0, cfg.width, 8'd0};
    h_lim = {4'd0, cfg.height, 8'd0};

    res_next.visible = !u[27] && (u < $signed(w_lim)) && !v[27] && (v < $signed(h_lim));
    if (u > 28'sd8388607) begin
      res_next.pixel_u = 24'sd8388607;
    end else if (u < -28'sd8388608) begin
      res_next.pixel_u = -24'sd8388608;
    end else begin
      res_next.pixel_u = u[23:0];
    end
    if (v > 28'sd8388607) begin
      res_next.pixel_v = 24'sd8388607;
    end else if (v < -28'sd8388608) begin
      res_next.pixel_v = -24'sd8388608;
    end else begin
      res_next.pixel_v = v[23:0];
    end
    res_next.size_pixels = (q_s[QW-1:24] != '0) ? 24'hFFFFFF : q_s[23:0];

    // behind or too near the camera
    if (side[LAT-1].near) begin
      res_next = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= side[LAT-1].valid;
    end
  end

  assign out_data = res;

  // a visible point lies at nonnegative coordinates
  a_vis_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.visible |-> !res.pixel_u[23] && !res.pixel_v[23])
    else $error("visible point with negative coordinate");

  // nothing is visible in an empty image
  a_vis_image: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.visible |-> cfg.width != 16'd0 && cfg.height != 16'd0)
    else $error("visible point in zero-size image");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

`default_nettype wire

@@ rtl/pinhole_point_projection.sv @@
// ----------------------------------------------------------------------------
// pinhole_point_projection
// Rotates body-frame points into the camera frame and projects them to
// pixel coordinates and an apparent size.
// ----------------------------------------------------------------------------
// The block takes one point per cycle while no stall holds back the
// flow, and returns one result per point, in order. A point passes the
// matrix rotation stages, a short queue, the focal product register, the
// bit-per-stage dividers and the output register. Throughput is one point
// per cycle, set by the fully pipelined divider lanes, unless out_ready or
// a full queue stalls it. Configuration is written through the cfg port,
// by the user, only while the block holds no points; the block does not check.
`default_nettype none

module pinhole_point_projection #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire  [2:0]       cfg_index,
  input  wire  [47:0]      cfg_data,
  input  wire              in_valid,
  output logic             in_ready,
  input  ppp_pkg::in_t     in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output ppp_pkg::out_t    out_data
);
  import ppp_pkg::*;

  logic [47:0] focal_pair, center_pair, row0, row1, row2;
  logic [31:0] image_size;
  cfg_t        cfg;
  logic        cam_valid, q_full, q_nonempty, q_pop;
  cam_t        cam_data, q_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_pair  <= '0;
      center_pair <= '0;
      image_size  <= '0;
      row0        <= '0;
      row1        <= '0;
      row2        <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FOCAL:  focal_pair  <= cfg_data;
        REG_CENTER: center_pair <= cfg_data;
        REG_IMAGE:  image_size  <= cfg_data[31:0];
        REG_ROW0:   row0        <= cfg_data;
        REG_ROW1:   row1        <= cfg_data;
        REG_ROW2:   row2        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.fx     = focal_pair[23:0];
  assign cfg.fy     = focal_pair[47:24];
  assign cfg.cx     = center_pair[23:0];
  assign cfg.cy     = center_pair[47:24];
  assign cfg.width  = image_size[15:0];
  assign cfg.height = image_size[31:16];
  assign cfg.mount  = {row2, row1, row0};

  ppp_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cam_valid(cam_valid), .cam_ready(!q_full), .cam_data(cam_data)
  );

  ppp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push(cam_valid), .push_data(cam_data), .full(q_full),
    .pop(q_pop), .nonempty(q_nonempty), .pop_data(q_data)
  );

  ppp_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .cam_valid(q_nonempty), .cam_pop(q_pop), .cam_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

`default_nettype wire
